// ----- design/mmtd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtd_pkg
// shared types, constants and elaboration helpers for the moebius unit
// ----------------------------------------------------------------------------
package mmtd_pkg;

    localparam int DEF_VALUE_WIDTH = 24;
    localparam int DEF_PRIME_DEPTH = 1024;
    localparam int SIEVE_MARGIN    = 1000;
    localparam int SEED_P0         = 2;
    localparam int SEED_P1         = 3;
    localparam int SEED_P2         = 5;
    localparam int FIRST_CAND      = 7;
    localparam int CAND_STEP       = 2;

    localparam logic signed [1:0] MU_POS  = 2'sb01;
    localparam logic signed [1:0] MU_NEG  = 2'sb11;
    localparam logic signed [1:0] MU_ZERO = 2'sb00;

    // floor square root of a constant, bit by bit
    function automatic longint isqrt_c(input longint v);
        longint r;
        longint t;
        r = 0;
        for (int b = 20; b >= 0; b--) begin
            t = r + (longint'(1) << b);
            if (t * t <= v) begin
                r = t;
            end
        end
        return r;
    endfunction

    // largest candidate tested when the prime table is filled
    function automatic int prime_limit(input int vw);
        return int'(SIEVE_MARGIN + isqrt_c((longint'(1) << vw) - 1));
    endfunction

    typedef enum logic [4:0] {
        OP_NONE,
        OP_WR_SEED,
        OP_FILL_START,
        OP_RD,
        OP_DIV_CAND,
        OP_DIV_NUM,
        OP_DIV_AGAIN,
        OP_MUL,
        OP_NEXT_IDX,
        OP_WR_PRIME,
        OP_NEXT_CAND,
        OP_LOAD_N,
        OP_TAKE_FACTOR,
        OP_RES_POS,
        OP_RES_NEG,
        OP_RES_ZERO,
        OP_RES_FINISH,
        OP_EMIT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } cmd_t;

    typedef struct packed {
        logic seed_last;
        logic cand_over;
        logic table_full;
        logic idx_end;
        logic k_zero;
        logic div_done;
        logic rem_zero;
        logic kk_gt_cand;
        logic kk_gt_num;
        logic num_le1;
        logic num_le3;
        logic num_one;
    } sts_t;

    typedef enum logic [4:0] {
        S_SEED,
        S_CAND,
        S_FJ,
        S_FRD,
        S_FDIV,
        S_FCMP,
        S_IDLE,
        S_CLASS,
        S_MJ,
        S_MRD,
        S_MDIV,
        S_MDIV2S,
        S_MDIV2,
        S_MCHK,
        S_MCMP,
        S_DONE
    } state_t;

endpackage

// ----- design/mmtd_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtd_div
// restoring serial divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module mmtd_div #(
    parameter int DW = 24,
    parameter int KW = 13
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [KW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quot,
    output logic [KW-1:0] rem
);
    localparam int SW = $clog2(DW + 1);

    logic [DW-1:0] q_reg, q_next;
    logic [KW-1:0] r_reg, r_next;
    logic [KW-1:0] d_reg, d_next;
    logic [SW-1:0] step_reg, step_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [KW:0]   shifted;
    logic          ge;

    assign shifted = {r_reg, q_reg[DW-1]};
    assign ge      = (shifted >= {1'b0, d_reg});

    always_comb
    begin
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            q_next = {q_reg[DW-2:0], ge};
            r_next = ge ? KW'(shifted - {1'b0, d_reg}) : shifted[KW-1:0];
            step_next = step_reg + 1'b1;
            if (step_reg == SW'(DW - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

// ----- design/mmtd_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtd_datapath
// prime table, working registers, shared divider and squaring multiplier
// ----------------------------------------------------------------------------
module mmtd_datapath #(
    parameter int VALUE_WIDTH = mmtd_pkg::DEF_VALUE_WIDTH,
    parameter int PRIME_DEPTH = mmtd_pkg::DEF_PRIME_DEPTH
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  mmtd_pkg::cmd_t          cmd,
    input  logic [VALUE_WIDTH-1:0]  value_in,
    output mmtd_pkg::sts_t          sts,
    output logic signed [1:0]       mu_out
);
    import mmtd_pkg::*;

    localparam int LIMIT  = prime_limit(VALUE_WIDTH);
    localparam int PW     = $clog2(LIMIT + CAND_STEP + 1);
    localparam int DW     = (VALUE_WIDTH > PW) ? VALUE_WIDTH : PW;
    localparam int AW     = $clog2(PRIME_DEPTH);
    localparam int CW     = $clog2(PRIME_DEPTH + 1);
    localparam int QW     = 2 * PW;
    localparam int XW     = (QW > DW) ? QW : DW;

    logic [PW-1:0] prime_mem [PRIME_DEPTH];
    logic [PW-1:0] rdata_reg;

    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [CW-1:0]          idx_reg, idx_next;
    logic [PW-1:0]          cand_reg, cand_next;
    logic [VALUE_WIDTH-1:0] num_reg, num_next;
    logic [PW-1:0]          k_reg, k_next;
    logic [QW-1:0]          kk_reg, kk_next;
    logic                   par_reg, par_next;
    logic signed [1:0]      res_reg, res_next;
    logic signed [1:0]      mu_reg, mu_next;

    logic                   div_start;
    logic [DW-1:0]          div_dividend;
    logic [PW-1:0]          div_divisor;
    logic                   div_done;
    logic [DW-1:0]          div_quot;
    logic [PW-1:0]          div_rem;
    logic                   wr_en;
    logic [PW-1:0]          wr_data;
    logic [PW-1:0]          seed_val;

    mmtd_div #(.DW(DW), .KW(PW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    always_comb
    begin
        unique case (cnt_reg)
            CW'(0):  seed_val = PW'(SEED_P0);
            CW'(1):  seed_val = PW'(SEED_P1);
            default: seed_val = PW'(SEED_P2);
        endcase
    end

    always_comb
    begin
        cnt_next     = cnt_reg;
        idx_next     = idx_reg;
        cand_next    = cand_reg;
        num_next     = num_reg;
        k_next       = k_reg;
        kk_next      = kk_reg;
        par_next     = par_reg;
        res_next     = res_reg;
        mu_next      = mu_reg;
        div_start    = 1'b0;
        div_dividend = DW'(num_reg);
        div_divisor  = rdata_reg;
        wr_en        = 1'b0;
        wr_data      = cand_reg;
        unique case (cmd.op)
            OP_WR_SEED:
            begin
                wr_en    = 1'b1;
                wr_data  = seed_val;
                cnt_next = cnt_reg + 1'b1;
            end
            OP_FILL_START: idx_next = CW'(1);
            OP_DIV_CAND:
            begin
                div_start    = 1'b1;
                div_dividend = DW'(cand_reg);
                k_next       = rdata_reg;
            end
            OP_DIV_NUM:
            begin
                div_start = 1'b1;
                k_next    = rdata_reg;
            end
            OP_DIV_AGAIN:
            begin
                div_start   = 1'b1;
                div_divisor = k_reg;
            end
            OP_MUL:      kk_next = QW'(k_reg) * QW'(k_reg);
            OP_NEXT_IDX: idx_next = idx_reg + 1'b1;
            OP_WR_PRIME:
            begin
                wr_en     = 1'b1;
                cnt_next  = cnt_reg + 1'b1;
                cand_next = cand_reg + PW'(CAND_STEP);
            end
            OP_NEXT_CAND: cand_next = cand_reg + PW'(CAND_STEP);
            OP_LOAD_N:
            begin
                num_next = value_in;
                idx_next = '0;
                par_next = 1'b0;
            end
            OP_TAKE_FACTOR:
            begin
                num_next = div_quot[VALUE_WIDTH-1:0];
                par_next = ~par_reg;
            end
            OP_RES_POS:    res_next = MU_POS;
            OP_RES_NEG:    res_next = MU_NEG;
            OP_RES_ZERO:   res_next = MU_ZERO;
            // a cofactor above one is one more prime
            OP_RES_FINISH:
                res_next = (par_reg ^ (num_reg > VALUE_WIDTH'(1))) ? MU_NEG : MU_POS;
            OP_EMIT:       mu_next = res_reg;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            cand_reg <= PW'(FIRST_CAND);
        end
        else
        begin
            cnt_reg  <= cnt_next;
            cand_reg <= cand_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        num_reg <= num_next;
        k_reg   <= k_next;
        kk_reg  <= kk_next;
        par_reg <= par_next;
        res_reg <= res_next;
        mu_reg  <= mu_next;
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            prime_mem[cnt_reg[AW-1:0]] <= wr_data;
        end
        if (cmd.op == OP_RD)
        begin
            rdata_reg <= prime_mem[idx_reg[AW-1:0]];
        end
    end

    always_comb
    begin
        sts.seed_last  = (cnt_reg == CW'(2));
        sts.cand_over  = (cand_reg > PW'(LIMIT));
        sts.table_full = (cnt_reg >= CW'(PRIME_DEPTH));
        sts.idx_end    = (idx_reg >= cnt_reg);
        sts.k_zero     = (rdata_reg == '0);
        sts.div_done   = div_done;
        sts.rem_zero   = (div_rem == '0);
        sts.kk_gt_cand = (XW'(kk_reg) > XW'(cand_reg));
        sts.kk_gt_num  = (XW'(kk_reg) > XW'(num_reg));
        sts.num_le1    = (num_reg <= VALUE_WIDTH'(1));
        sts.num_le3    = (num_reg <= VALUE_WIDTH'(3));
        sts.num_one    = (num_reg == VALUE_WIDTH'(1));
    end

    assign mu_out = mu_reg;

endmodule

// ----- design/mmtd_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mmtd_ctrl
// sequencer for table fill, trial division walk and output handshake
// ----------------------------------------------------------------------------
module mmtd_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    input  logic           out_ready,
    input  mmtd_pkg::sts_t sts,
    output mmtd_pkg::cmd_t cmd,
    output logic           in_ready,
    output logic           out_valid
);
    import mmtd_pkg::*;

    state_t state_reg, state_next;
    logic   ov_reg, ov_next;
    logic   emit_ok;

    assign emit_ok = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_SEED:   if (sts.seed_last) state_next = S_CAND;
            S_CAND:   state_next = (sts.cand_over || sts.table_full) ? S_IDLE : S_FJ;
            S_FJ:     state_next = sts.idx_end ? S_CAND : S_FRD;
            S_FRD:    state_next = S_FDIV;
            S_FDIV:
                if (sts.div_done) state_next = sts.rem_zero ? S_CAND : S_FCMP;
            S_FCMP:   state_next = sts.kk_gt_cand ? S_CAND : S_FJ;
            S_IDLE:   if (in_valid) state_next = S_CLASS;
            S_CLASS:  state_next = (sts.num_le1 || sts.num_le3) ? S_DONE : S_MJ;
            S_MJ:     state_next = sts.idx_end ? S_DONE : S_MRD;
            S_MRD:    state_next = sts.k_zero ? S_DONE : S_MDIV;
            S_MDIV:
                if (sts.div_done) state_next = sts.rem_zero ? S_MDIV2S : S_MCHK;
            S_MDIV2S: state_next = S_MDIV2;
            S_MDIV2:
                if (sts.div_done) state_next = sts.rem_zero ? S_DONE : S_MCHK;
            S_MCHK:   state_next = sts.num_one ? S_DONE : S_MCMP;
            S_MCMP:   state_next = sts.kk_gt_num ? S_DONE : S_MJ;
            S_DONE:   if (emit_ok) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op   = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            S_SEED:  cmd.op = OP_WR_SEED;
            S_CAND:  if (!(sts.cand_over || sts.table_full)) cmd.op = OP_FILL_START;
            S_FJ:    cmd.op = sts.idx_end ? OP_WR_PRIME : OP_RD;
            S_FRD:   cmd.op = OP_DIV_CAND;
            S_FDIV:
                if (sts.div_done) cmd.op = sts.rem_zero ? OP_NEXT_CAND : OP_MUL;
            S_FCMP:  cmd.op = sts.kk_gt_cand ? OP_WR_PRIME : OP_NEXT_IDX;
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid) cmd.op = OP_LOAD_N;
            end
            S_CLASS:
                if (sts.num_le1)      cmd.op = OP_RES_POS;
                else if (sts.num_le3) cmd.op = OP_RES_NEG;
            S_MJ:    cmd.op = sts.idx_end ? OP_RES_FINISH : OP_RD;
            S_MRD:   cmd.op = sts.k_zero ? OP_RES_FINISH : OP_DIV_NUM;
            S_MDIV:
                if (sts.div_done && sts.rem_zero) cmd.op = OP_TAKE_FACTOR;
            S_MDIV2S: cmd.op = OP_DIV_AGAIN;
            S_MDIV2:
                if (sts.div_done && sts.rem_zero) cmd.op = OP_RES_ZERO;
            S_MCHK:  cmd.op = sts.num_one ? OP_RES_FINISH : OP_MUL;
            S_MCMP:  cmd.op = sts.kk_gt_num ? OP_RES_FINISH : OP_NEXT_IDX;
            S_DONE:  if (emit_ok) cmd.op = OP_EMIT;
            default: cmd.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        ov_next = ov_reg;
        if (ov_reg && out_ready)
        begin
            ov_next = 1'b0;
        end
        if (state_reg == S_DONE && emit_ok)
        begin
            ov_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_SEED;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    assign out_valid = ov_reg;

endmodule

// ----- design/moebius_mu_trial_division_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// moebius_mu_trial_division_core
// moebius function mu(n) by trial division over a prime table built at reset
// ----------------------------------------------------------------------------
//  channel | signals                         | role
//  --------+---------------------------------+-------------------------------
//  input   | in_valid, in_ready, value_in    | one n per transaction
//  output  | out_valid, out_ready, mu_out    | one mu (-1, 0, +1) per input
//
//  one item at a time; each prime tried costs a memory read plus one serial
//  division (two when the prime divides n), for the primes up to sqrt(n)
//  after reset the table is filled by testing odd candidates against the
//  primes found so far, using the same divider; in_ready stays low until done
//  a finished result sits in the output register; the next n is accepted
//  while it waits, and that item stalls only at its own end
// ----------------------------------------------------------------------------
module moebius_mu_trial_division_core #(
    parameter int VALUE_WIDTH = mmtd_pkg::DEF_VALUE_WIDTH,
    parameter int PRIME_DEPTH = mmtd_pkg::DEF_PRIME_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [VALUE_WIDTH-1:0] value_in,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic signed [1:0]      mu_out
);
    import mmtd_pkg::*;

    // command from the sequencer, flags back from the datapath
    cmd_t cmd;
    sts_t sts;

    mmtd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_ready (out_ready),
        .sts       (sts),
        .cmd       (cmd),
        .in_ready  (in_ready),
        .out_valid (out_valid)
    );

    mmtd_datapath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .PRIME_DEPTH (PRIME_DEPTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .value_in (value_in),
        .sts      (sts),
        .mu_out   (mu_out)
    );

    // an accepted transaction moves the unit out of idle and drops in_ready
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // emitting a result always raises out_valid
    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |=> out_valid)
        else $error("emit without out_valid");

    // a result is never emitted while an untaken one is still held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EMIT) |-> (!out_valid || out_ready))
        else $error("pending result overwritten");

endmodule

// ----- test/tb_moebius_mu_trial_division_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_moebius_mu_trial_division_core
// checks mu(n) results against a local trial-division predictor; directed
// corner values first, then mostly small random n with squareful and
// square-free products mixed in, under varying handshake idling on both sides
// ----------------------------------------------------------------------------
module tb_moebius_mu_trial_division_core;

    import mmtd_pkg::*;

    localparam int VW          = DEF_VALUE_WIDTH;
    localparam int DEPTH       = DEF_PRIME_DEPTH;
    localparam int MARGIN      = 1000;
    localparam int N_RANDOM    = 1230;
    localparam longint MAX_CYC = 40_000_000;

    // scoreboard: owns the prime table copy and the queue of pending mu values
    class mu_scoreboard;
        int unsigned primes[DEPTH];
        int unsigned n_primes;
        logic signed [1:0] mu_queue[$];
        logic [VW-1:0] n_queue[$];
        int errors;

        function new();
            longint lim;
            longint r;
            longint cand;
            int unsigned cnt;
            bit is_p;
            errors = 0;
            r = 0;
            while ((r + 1) * (r + 1) <= ((longint'(1) << VW) - 1)) r++;
            lim = MARGIN + r;
            foreach (primes[i]) primes[i] = 0;
            primes[0] = 2;
            primes[1] = 3;
            primes[2] = 5;
            cnt = 3;
            for (cand = 7; cand <= lim && cnt < DEPTH; cand += 2) begin
                is_p = 1;
                for (int j = 1; j < cnt; j++) begin
                    if (cand % primes[j] == 0) begin
                        is_p = 0;
                        break;
                    end
                    if (longint'(primes[j]) * primes[j] > cand) break;
                end
                if (is_p) begin
                    primes[cnt] = 32'(cand);
                    cnt++;
                end
            end
            n_primes = cnt;
        endfunction

        function logic signed [1:0] mu_of(logic [VW-1:0] v);
            longint n;
            longint k;
            int unsigned odd_cnt;
            bit finished;
            n = longint'(v);
            odd_cnt = 0;
            finished = 0;
            if (n <= 1) return MU_POS;
            if (n <= 3) return MU_NEG;
            for (int i = 0; i < n_primes; i++) begin
                k = longint'(primes[i]);
                if (k == 0) break;
                if (n % k == 0) begin
                    odd_cnt++;
                    n = n / k;
                    if (n % k == 0) return MU_ZERO;
                end
                if (n == 1) begin
                    finished = 1;
                    break;
                end
                if (k * k > n) begin
                    odd_cnt++;
                    finished = 1;
                    break;
                end
            end
            if (!finished && n > 1) odd_cnt++;
            return odd_cnt[0] ? MU_NEG : MU_POS;
        endfunction

        function void note_input(logic [VW-1:0] v);
            mu_queue.push_back(mu_of(v));
            n_queue.push_back(v);
        endfunction

        function void check_result(logic signed [1:0] got);
            logic signed [1:0] want;
            logic [VW-1:0] v;
            if (mu_queue.size() == 0) begin
                $display("%0t: unexpected result mu=%0d, expected none", $time, got);
                errors++;
                return;
            end
            want = mu_queue.pop_front();
            v = n_queue.pop_front();
            if (got !== want) begin
                $display("%0t: n=%0d expected mu=%0d actual mu=%0d", $time, v, want, got);
                errors++;
            end
        endfunction

        function int pending();
            return mu_queue.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    logic [VW-1:0] value_in;
    logic out_valid;
    logic out_ready;
    logic signed [1:0] mu_out;

    mu_scoreboard sb;
    int in_idle_pct;
    int out_idle_pct;
    longint cycles;

    moebius_mu_trial_division_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .value_in (value_in),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .mu_out   (mu_out)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // timeout guard, sized for the table fill plus worst-case long walks
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYC) begin
            $display("[moebius_mu_trial_division_core] ERROR");
            $finish;
        end
    end

    // result side: check each accepted transaction, then pick next ready
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_result(mu_out);
            out_ready <= ($urandom_range(99) >= out_idle_pct);
        end
    end

    // one input transaction, with an optional idle gap afterward
    task automatic send_value(logic [VW-1:0] v);
        in_valid <= 1'b1;
        value_in <= v;
        forever
        begin
            @(posedge clk);
            if (in_ready) break;
        end
        sb.note_input(v);
        if ($urandom_range(99) < in_idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // hold the input low until every pending result has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0) @(posedge clk);
    endtask

    // random n; most are small so trial division stays short
    function automatic logic [VW-1:0] pick_value();
        int sel;
        int unsigned p;
        logic [VW-1:0] v;
        sel = $urandom_range(99);
        if (sel < 40) begin
            v = VW'($urandom_range(4095));
        end else if (sel < 55) begin
            v = VW'($urandom_range(65535));
        end else if (sel < 60) begin
            // full width, reaches every input bit
            v = VW'($urandom());
        end else if (sel < 80) begin
            // squareful: small multiple of a prime squared
            p = sb.primes[$urandom_range(40)];
            v = VW'(p * p * $urandom_range(1, 200));
        end else begin
            // square-free product of distinct small primes
            v = VW'(1);
            for (int i = 0; i < 48; i++) begin
                if ($urandom_range(9) == 0 && longint'(v) * sb.primes[i] < 65536)
                    v = VW'(v * sb.primes[i]);
            end
        end
        return v;
    endfunction

    initial
    begin
        logic [VW-1:0] corners[$];
        sb = new();
        cycles = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        value_in = '0;
        out_ready = 1'b0;
        in_idle_pct = 12;
        out_idle_pct = 51;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero and one, two and three, small cases, cofactor above sqrt,
        // square and product of the largest primes below 4096, all-ones and top bit
        corners = '{0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 12, 30, 210, 2310, 4096, 4097,
                    2 * 4093, 4093 * 4093, 4093 * 4091, 16777213, 16777215,
                    24'h800000, 24'h7fffff, 24'h555555, 24'haaaaaa};
        foreach (corners[i]) send_value(corners[i]);
        drain();

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin in_idle_pct = 12; out_idle_pct = 51; end
                1: begin in_idle_pct = 51; out_idle_pct = 12; end
                default: begin in_idle_pct = 0; out_idle_pct = 0; end
            endcase
            for (int i = 0; i < N_RANDOM / 3; i++) send_value(pick_value());
            drain();
        end

        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("[moebius_mu_trial_division_core] OK");
        else
            $display("[moebius_mu_trial_division_core] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/mmtd_pkg.sv
design/mmtd_div.sv
design/mmtd_datapath.sv
design/mmtd_ctrl.sv
design/moebius_mu_trial_division_core.sv
test/tb_moebius_mu_trial_division_core.sv
